FILE: rtl/crcfb_pkg.sv
`default_nettype none

package crcfb_pkg;

    localparam int unsigned DEV_ID_W = 32;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned POS_W    = 4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    localparam logic [7:0]       SOF_BYTE     = 8'h68;
    localparam logic [7:0]       TRAILER_BYTE = 8'h16;
    localparam logic [CRC_W-1:0] CRC_INIT     = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY     = 16'hA001;

    // positions within the byte sequence caused by one transaction
    localparam logic [POS_W-1:0] POS_SOF     = 4'd0;
    localparam logic [POS_W-1:0] POS_ID0_B3  = 4'd1;
    localparam logic [POS_W-1:0] POS_ID0_B2  = 4'd2;
    localparam logic [POS_W-1:0] POS_ID0_B1  = 4'd3;
    localparam logic [POS_W-1:0] POS_ID0_B0  = 4'd4;
    localparam logic [POS_W-1:0] POS_ID1_B3  = 4'd5;
    localparam logic [POS_W-1:0] POS_ID1_B2  = 4'd6;
    localparam logic [POS_W-1:0] POS_ID1_B1  = 4'd7;
    localparam logic [POS_W-1:0] POS_ID1_B0  = 4'd8;
    localparam logic [POS_W-1:0] POS_CODE    = 4'd9;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 4'd10;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 4'd11;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd12;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd13;
    localparam logic [POS_W-1:0] POS_TRAILER = 4'd14;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/crc_frame_builder_top.sv
`default_nettype none

// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------------
// input     | i_valid / o_ready   | i_req_type, i_frame_code, i_frame_length,
//           |                     | i_data_byte
// output    | o_valid / i_ready   | o_out_byte, o_end_of_run, o_end_of_frame, o_error
// config    | i_cfg_we            | i_cfg_data (device id)
//
// one output byte per cycle unless the output stalls; a payload transaction
// not closing the frame leaves the sequencer idle, so these flow back to back;
// a start sends sof, id twice, code and length (crc, trailer too if length is 0),
// a closing byte data, crc, trailer; one byte sequencer feeds the output register
// synchronous active-low reset clears the frame state, crc and device id
// a stalled output holds its register and blocks new input transactions

module crc_frame_builder_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [crcfb_pkg::DEV_ID_W-1:0] i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_req_type,
    input  wire logic [7:0]                    i_frame_code,
    input  wire logic [crcfb_pkg::LEN_W-1:0]   i_frame_length,
    input  wire logic [7:0]                    i_data_byte,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_end_of_run,
    output logic                               o_end_of_frame,
    output logic                               o_error
);
    import crcfb_pkg::*;

    logic [DEV_ID_W-1:0] r_device_id;
    logic [CRC_W-1:0]    r_crc;
    logic [LEN_W-1:0]    r_bytes_left;
    logic                r_frame_open;
    logic                r_busy;
    logic [POS_W-1:0]    r_pos;
    logic                r_req;
    logic [7:0]          r_code;
    logic [LEN_W-1:0]    r_len;

    logic                r_o_valid;
    logic [7:0]          r_o_byte;
    logic                r_o_eor;
    logic                r_o_eof;
    logic                r_o_err;

    logic                advance;
    logic                step;
    logic                accept;
    logic                cur_req;
    logic [7:0]          cur_code;
    logic [LEN_W-1:0]    cur_len;
    logic [POS_W-1:0]    cur_pos;
    logic [CRC_W-1:0]    crc_base;
    logic [7:0]          e_byte;
    logic                e_feed;
    logic                e_last;
    logic                e_eof;
    logic                e_err;
    logic [CRC_W-1:0]    n_crc;
    logic [LEN_W-1:0]    n_bytes_left;
    logic                n_frame_open;
    logic [POS_W-1:0]    n_pos;

    assign advance = !r_o_valid || i_ready;
    assign o_ready = advance && !r_busy;
    assign accept  = o_ready && i_valid;
    assign step    = advance && (r_busy || i_valid);

    always_comb begin
        cur_req  = r_busy ? r_req  : i_req_type;
        cur_code = r_busy ? r_code : i_frame_code;
        cur_len  = r_busy ? r_len  : i_frame_length;
        cur_pos  = r_busy ? r_pos  : POS_SOF;
        crc_base = (cur_req == REQ_START && cur_pos == POS_SOF) ? CRC_INIT : r_crc;

        e_byte       = 8'h00;
        e_feed       = 1'b0;
        e_last       = 1'b0;
        e_eof        = 1'b0;
        e_err        = 1'b0;
        n_bytes_left = r_bytes_left;
        n_frame_open = r_frame_open;
        n_pos        = cur_pos + 4'd1;

        if (cur_pos inside {POS_CRC_LO, POS_CRC_HI, POS_TRAILER}) begin
            case (cur_pos)
                POS_CRC_LO: begin
                    e_byte = r_crc[7:0];
                end
                POS_CRC_HI: begin
                    e_byte = r_crc[15:8];
                end
                default: begin
                    e_byte       = TRAILER_BYTE;
                    e_eof        = 1'b1;
                    e_last       = 1'b1;
                    n_bytes_left = '0;
                    n_frame_open = 1'b0;
                end
            endcase
        end else if (cur_req == REQ_START) begin
            e_feed = 1'b1;
            case (cur_pos)
                POS_SOF:                e_byte = SOF_BYTE;
                POS_ID0_B3, POS_ID1_B3: e_byte = r_device_id[31:24];
                POS_ID0_B2, POS_ID1_B2: e_byte = r_device_id[23:16];
                POS_ID0_B1, POS_ID1_B1: e_byte = r_device_id[15:8];
                POS_ID0_B0, POS_ID1_B0: e_byte = r_device_id[7:0];
                POS_CODE:               e_byte = cur_code;
                POS_LEN_LO:             e_byte = cur_len[7:0];
                POS_LEN_HI: begin
                    e_byte = cur_len[15:8];
                    if (cur_len != '0) begin
                        e_last       = 1'b1;
                        n_bytes_left = cur_len;
                        n_frame_open = 1'b1;
                    end
                end
                default:                e_byte = 8'h00;
            endcase
        end else if (!r_frame_open) begin
            e_err  = 1'b1;
            e_last = 1'b1;
        end else begin
            e_byte       = i_data_byte;
            e_feed       = 1'b1;
            n_bytes_left = r_bytes_left - 16'd1;
            if (r_bytes_left == 16'd1) begin
                n_pos = POS_CRC_LO;
            end else begin
                e_last = 1'b1;
            end
        end

        if (e_eof) begin
            n_crc = CRC_INIT;
        end else if (e_feed) begin
            n_crc = crc_byte(crc_base, e_byte);
        end else begin
            n_crc = r_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id  <= '0;
            r_crc        <= CRC_INIT;
            r_bytes_left <= '0;
            r_frame_open <= 1'b0;
            r_busy       <= 1'b0;
            r_pos        <= POS_SOF;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_device_id <= i_cfg_data;
            end
            if (step) begin
                r_crc        <= n_crc;
                r_bytes_left <= n_bytes_left;
                r_frame_open <= n_frame_open;
                r_busy       <= !e_last;
                r_pos        <= n_pos;
            end
            if (advance) begin
                r_o_valid <= step;
            end
        end
    end

    // held transaction and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_code <= i_frame_code;
            r_len  <= i_frame_length;
        end
        if (step) begin
            r_o_byte <= e_byte;
            r_o_eor  <= e_last;
            r_o_eof  <= e_eof;
            r_o_err  <= e_err;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_end_of_run   = r_o_eor;
    assign o_end_of_frame = r_o_eof;
    assign o_error        = r_o_err;

endmodule

`default_nettype wire

FILE: test/testbench.sv
`default_nettype none

module testbench;

    import crcfb_pkg::*;

    typedef struct packed {
        logic             req;
        logic [7:0]       code;
        logic [LEN_W-1:0] len;
        logic [7:0]       dat;
    } t_frame_req;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       frame_end;
        logic       err;
    } t_wire_byte;

    typedef struct packed {
        t_frame_req item;
        logic       typed;
        t_wire_byte want;
    } t_dir_row;

    localparam t_wire_byte NO_FRAME = '{data: 8'h00, run_end: 1'b1, frame_end: 1'b0, err: 1'b1};
    localparam int N_DIR       = 22;
    localparam int N_PHASES    = 5;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // payload transactions with no frame open carry their expected result
    t_dir_row dir_tab [N_DIR] = '{
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'hFF}, 1'b1, NO_FRAME},
        '{'{REQ_DATA,  8'hFF, 16'hFFFF, 8'h00}, 1'b1, NO_FRAME},
        '{'{REQ_START, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{REQ_START, 8'hFF, 16'h0000, 8'hFF}, 1'b0, '0},
        '{'{REQ_START, 8'hA5, 16'h0001, 8'h00}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'hFF}, 1'b0, '0},
        '{'{REQ_START, 8'h5A, 16'h0003, 8'h00}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'h80}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'h7F}, 1'b0, '0},
        '{'{REQ_DATA,  8'h12, 16'h0002, 8'h55}, 1'b1, NO_FRAME},
        '{'{REQ_START, 8'h3C, 16'hFFFF, 8'h00}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'h12}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'h34}, 1'b0, '0},
        '{'{REQ_START, 8'hC3, 16'h8000, 8'h00}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'hAA}, 1'b0, '0},
        '{'{REQ_START, 8'h96, 16'h0002, 8'h00}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'h01}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'hFE}, 1'b0, '0},
        '{'{REQ_DATA,  8'hFF, 16'hFFFF, 8'h00}, 1'b1, NO_FRAME},
        '{'{REQ_START, 8'hF0, 16'h0001, 8'h00}, 1'b0, '0},
        '{'{REQ_DATA,  8'h00, 16'h0000, 8'h5A}, 1'b0, '0}
    };

    int unsigned tx_pct [N_PHASES] = '{0, 62, 0, 10, 0};
    int unsigned rx_pct [N_PHASES] = '{0, 0, 62, 10, 0};

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [DEV_ID_W-1:0] i_cfg_data     = '0;
    logic                i_valid        = 1'b0;
    logic                o_ready;
    logic                i_req_type     = 1'b0;
    logic [7:0]          i_frame_code   = '0;
    logic [LEN_W-1:0]    i_frame_length = '0;
    logic [7:0]          i_data_byte    = '0;
    logic                o_valid;
    logic                i_ready        = 1'b0;
    logic [7:0]          o_out_byte;
    logic                o_end_of_run;
    logic                o_end_of_frame;
    logic                o_error;

    // frame builder state as predicted
    logic [DEV_ID_W-1:0] dev_id       = '0;
    logic [CRC_W-1:0]    crc_run      = CRC_INIT;
    logic [LEN_W-1:0]    pay_left     = '0;
    logic                frame_active = 1'b0;

    t_wire_byte  burst_q [$];
    t_wire_byte  frame_bytes_q [$];
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int          hold_left    = 0;
    logic        hold_req     = 1'b0;

    crc_frame_builder_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_frame_code   (i_frame_code),
        .i_frame_length (i_frame_length),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_end_of_run   (o_end_of_run),
        .o_end_of_frame (o_end_of_frame),
        .o_error        (o_error)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic push_frame_byte(input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_run ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_run = c;
        burst_q.push_back('{b, 1'b0, 1'b0, 1'b0});
    endtask

    task automatic push_frame_tail();
        burst_q.push_back('{crc_run[7:0], 1'b0, 1'b0, 1'b0});
        burst_q.push_back('{crc_run[15:8], 1'b0, 1'b0, 1'b0});
        burst_q.push_back('{TRAILER_BYTE, 1'b0, 1'b1, 1'b0});
        crc_run      = CRC_INIT;
        pay_left     = '0;
        frame_active = 1'b0;
    endtask

    task automatic predict_frame_bytes(input t_frame_req it);
        t_wire_byte tail_b;
        burst_q.delete();
        if (it.req == REQ_START) begin
            crc_run = CRC_INIT;
            push_frame_byte(SOF_BYTE);
            repeat (2) begin
                for (int k = 3; k >= 0; k--) begin
                    push_frame_byte(dev_id[8*k +: 8]);
                end
            end
            push_frame_byte(it.code);
            push_frame_byte(it.len[7:0]);
            push_frame_byte(it.len[15:8]);
            if (it.len == 0) begin
                push_frame_tail();
            end else begin
                pay_left     = it.len;
                frame_active = 1'b1;
            end
        end else if (!frame_active) begin
            burst_q.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
        end else begin
            push_frame_byte(it.dat);
            pay_left = pay_left - 16'd1;
            if (pay_left == 0) begin
                push_frame_tail();
            end
        end
        tail_b = burst_q[burst_q.size()-1];
        tail_b.run_end = 1'b1;
        burst_q[burst_q.size()-1] = tail_b;
    endtask

    // called just after a rising edge; returns at the edge that accepts the transaction
    task automatic send_item(input t_frame_req it, input logic typed, input t_wire_byte want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= it.req;
        i_frame_code   <= it.code;
        i_frame_length <= it.len;
        i_data_byte    <= it.dat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_frame_bytes(it);
        if (typed) begin
            frame_bytes_q.push_back(want);
        end else begin
            foreach (burst_q[i]) frame_bytes_q.push_back(burst_q[i]);
        end
    endtask

    function automatic t_frame_req random_req(input logic req);
        t_frame_req it;
        it.req  = req;
        it.code = 8'($urandom);
        it.len  = 16'($urandom);
        it.dat  = 8'($urandom);
        return it;
    endfunction

    task automatic send_random_frames(input int n_items);
        t_frame_req it;
        int         sent;
        int         cut;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0: begin
                    send_item(random_req(REQ_DATA), 1'b0, '0);
                    sent++;
                end
                1: begin
                    // frame cut short by the next start
                    it  = random_req(REQ_START);
                    cut = $urandom_range(3);
                    if (it.len != 0 && cut >= it.len) cut = it.len - 1;
                    send_item(it, 1'b0, '0);
                    repeat (cut) send_item(random_req(REQ_DATA), 1'b0, '0);
                    sent += 1 + cut;
                end
                default: begin
                    it     = random_req(REQ_START);
                    it.len = ($urandom_range(7) == 0) ? 16'($urandom_range(40))
                                                      : 16'($urandom_range(6));
                    send_item(it, 1'b0, '0);
                    repeat (it.len) send_item(random_req(REQ_DATA), 1'b0, '0);
                    sent += 1 + it.len;
                end
            endcase
        end
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_device_id(input logic [DEV_ID_W-1:0] v);
        wait_for_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dev_id = v;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %h, actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : check_bytes
        t_wire_byte want;
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_bytes_q.size() == 0) begin
                $display("%0t out_byte: expected none, actual %h", $time, o_out_byte);
                mismatch_cnt++;
            end else begin
                want = frame_bytes_q.pop_front();
                check_field("out_byte", want.data, o_out_byte);
                check_field("end_of_run", {7'd0, want.run_end}, {7'd0, o_end_of_run});
                check_field("end_of_frame", {7'd0, want.frame_end}, {7'd0, o_end_of_frame});
                check_field("error", {7'd0, want.err}, {7'd0, o_error});
            end
        end
    end

    // receiver side, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_DIR; i++) begin
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        end
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       load_device_id(32'hFFFF_FFFF);
                2:       load_device_id(32'h0000_0000);
                default: load_device_id($urandom);
            endcase
            tx_idle_pct  = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            if (p == N_PHASES - 1) begin
                // receiver holds off while transactions are offered, then the sender waits for the drain
                hold_req = 1'b1;
                send_random_frames(36);
                wait_for_drain();
                send_random_frames(36);
            end else begin
                send_random_frames(72);
            end
        end
        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/crcfb_pkg.sv
rtl/crc_frame_builder_top.sv
test/testbench.sv
